@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each use names the assertion and gives the antecedent, the consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock while out of reset.
`define PCS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/pcs_pkg.sv @@
package pcs_pkg;

	localparam int COORD_W    = 16;
	localparam int MAG_W      = COORD_W;            // |b - a| of two coords
	localparam int NORM_W     = 2 * MAG_W + 1;      // |v|^2 and |dot|
	localparam int COS2_W     = 17;
	localparam int MUL_A_W    = NORM_W;
	localparam int MUL_B_W    = COS2_W;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int SQ_W       = 2 * NORM_W;         // dot^2 and |v1|^2*|v2|^2
	localparam int Q_SHIFT    = 16;
	localparam int LHS_W      = SQ_W + Q_SHIFT;
	localparam int RHS_W      = SQ_W + COS2_W;
	localparam int ACC_W      = RHS_W + 1;
	localparam int PLANE_W    = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COS2_W;
	localparam int MAX_RES    = 4;
	localparam int QIDX_W     = $clog2(MAX_RES);
	localparam int QCNT_W     = QIDX_W + 1;

	localparam logic [COS2_W-1:0] COS2_RESET = 17'd64225;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COS2  = 1'b0,
		CFG_PLANE = 1'b1
	} cfg_idx_t;

	typedef enum logic [PLANE_W-1:0] {
		PLANE_XZ = 2'd0,
		PLANE_XY = 2'd1,
		PLANE_YZ = 2'd2
	} plane_t;

	typedef enum logic [1:0] {
		KIND_CONT  = 2'd0,
		KIND_START = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SEEN_NONE = 2'd0,
		SEEN_ONE  = 2'd1,
		SEEN_TWO  = 2'd2
	} seen_t;

	typedef enum logic [1:0] {
		SH_NONE = 2'd0,
		SH_B    = 2'd1,
		SH_A    = 2'd2
	} mac_shift_t;

	typedef struct packed {
		logic       en;
		logic       clear;
		logic       neg;
		mac_shift_t shift;
	} mac_ctl_t;

	typedef struct packed {
		logic done;
		logic smooth;
	} ang_res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		point_t pt;
		kind_t  kind;
	} res_t;

	typedef enum logic [3:0] {
		A_IDLE,
		A_M1,
		A_M2,
		A_M3,
		A_M4,
		A_M5,
		A_M6,
		A_M7,
		A_M8,
		A_M9,
		A_M10,
		A_M11,
		A_M12,
		A_CMP
	} ang_step_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_DISPATCH,
		T_CAND_WAIT,
		T_MAIN_START,
		T_MAIN_WAIT,
		T_END,
		T_DRAIN
	} top_state_t;

endpackage

@@ sv/polyline_corner_segmenter_unit.sv @@
// Cuts an ordered stream of 3D points into straight runs. Each point is passed on tagged
// "continues run" or "starts run"; a sharp point is held back until the next point shows
// whether it is a real corner or noise, and the point flagged stream_last is followed by an
// end marker, after which a fresh stream may begin. Only one point is in work at a time:
// in_stall is high from the transfer of a point until the cycle after its last result has
// been moved into the output register. A point that needs no angle test (the first two of a
// stream) goes from dispatch straight to the end step and the draining of its results. Each
// angle test takes twelve passes through a single 33x17-bit multiply-accumulate unit and one
// compare, and then hands back its result. A second test on the same point is launched from
// its own start state, so a point that confirms a corner and is then tested again keeps
// the block busy through both tests in turn.
// Configuration writes are taken at any time but must only be issued while the block is idle.
`include "assert_macros.svh"

module polyline_corner_segmenter_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pcs_pkg::COORD_W-1:0]    point_x,
	input  logic signed [pcs_pkg::COORD_W-1:0]    point_y,
	input  logic signed [pcs_pkg::COORD_W-1:0]    point_z,
	input  logic                                  stream_last,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [pcs_pkg::COORD_W-1:0]    out_x,
	output logic signed [pcs_pkg::COORD_W-1:0]    out_y,
	output logic signed [pcs_pkg::COORD_W-1:0]    out_z,
	output logic [1:0]                            kind,
	output logic                                  last_of_item,
	input  logic                                  cfg_we,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import pcs_pkg::*;

	top_state_t         state_q, state_d;
	logic [COS2_W-1:0]  cos2_q;
	logic [PLANE_W-1:0] plane_q;
	point_t             p_q, prev_q, vert_q, cand_q;
	logic               last_q;
	logic               cand_valid_q;
	seen_t              seen_q;
	res_t               q_q [MAX_RES];
	logic [QCNT_W-1:0]  cnt_q, rd_q, cnt_p1;
	logic               out_valid_q;
	res_t               out_q;
	logic               out_last_q;
	logic               ang_start;
	ang_res_t           ang_res;
	logic               push0, push1;
	res_t               d0, d1;
	logic               load;
	logic               accept;

	pcs_angle u_angle (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ang_start),
		.plane  (plane_q),
		.cos2   (cos2_q),
		.pa     (prev_q),
		.pb     (vert_q),
		.pc     (p_q),
		.res    (ang_res)
	);

	always_comb begin
		unique case (state_q)
			T_IDLE:       state_d = in_valid ? T_DISPATCH : T_IDLE;
			T_DISPATCH: begin
				if (seen_q == SEEN_TWO) begin
					state_d = cand_valid_q ? T_CAND_WAIT : T_MAIN_WAIT;
				end else begin
					state_d = T_END;
				end
			end
			T_CAND_WAIT: begin
				if (ang_res.done) begin
					state_d = ang_res.smooth ? T_END : T_MAIN_START;
				end else begin
					state_d = T_CAND_WAIT;
				end
			end
			T_MAIN_START: state_d = T_MAIN_WAIT;
			T_MAIN_WAIT:  state_d = ang_res.done ? T_END : T_MAIN_WAIT;
			T_END:        state_d = T_DRAIN;
			T_DRAIN:      state_d = (rd_q == cnt_q) ? T_IDLE : T_DRAIN;
			default:      state_d = T_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != T_IDLE);
		accept    = (state_q == T_IDLE) && in_valid;
		ang_start = ((state_q == T_DISPATCH) && (seen_q == SEEN_TWO)) ||
			(state_q == T_MAIN_START);
		load      = (state_q == T_DRAIN) && (rd_q != cnt_q) &&
			(!out_valid_q || !out_stall);
		cnt_p1    = cnt_q + QCNT_W'(1);
		push0     = 1'b0;
		push1     = 1'b0;
		d0        = '{pt: p_q, kind: KIND_CONT};
		d1        = '{pt: cand_q, kind: KIND_CONT};
		unique case (state_q)
			T_DISPATCH: begin
				if (seen_q == SEEN_NONE) begin
					push0   = 1'b1;
					d0.kind = KIND_START;
				end else if (seen_q == SEEN_ONE) begin
					push0 = 1'b1;
				end
			end
			T_CAND_WAIT: begin
				if (ang_res.done) begin
					push0 = 1'b1;
					if (!ang_res.smooth) begin
						// confirmed corner: vertex opens the new run, candidate follows
						d0    = '{pt: vert_q, kind: KIND_START};
						push1 = 1'b1;
					end
				end
			end
			T_MAIN_WAIT: begin
				push0 = ang_res.done && ang_res.smooth;
			end
			T_END: begin
				if (last_q) begin
					push0 = 1'b1;
					d0    = '{pt: '0, kind: KIND_END};
				end
			end
			T_IDLE, T_MAIN_START, T_DRAIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			cos2_q       <= COS2_RESET;
			plane_q      <= PLANE_XZ;
			cand_valid_q <= 1'b0;
			seen_q       <= SEEN_NONE;
			cnt_q        <= '0;
			rd_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == CFG_COS2) begin
				cos2_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_PLANE) begin
				plane_q <= cfg_data[PLANE_W-1:0];
			end
			if (accept) begin
				cnt_q <= '0;
				rd_q  <= '0;
			end else begin
				cnt_q <= cnt_q + QCNT_W'(push0) + QCNT_W'(push1);
				if (load) begin
					rd_q <= rd_q + QCNT_W'(1);
				end
			end
			if (state_q == T_DISPATCH && seen_q == SEEN_NONE) begin
				seen_q <= SEEN_ONE;
			end else if (state_q == T_DISPATCH && seen_q == SEEN_ONE) begin
				seen_q <= SEEN_TWO;
			end
			if (state_q == T_CAND_WAIT && ang_res.done) begin
				cand_valid_q <= 1'b0;
			end
			if (state_q == T_MAIN_WAIT && ang_res.done && !ang_res.smooth) begin
				cand_valid_q <= 1'b1;
			end
			// stream end drops any pending candidate
			if (state_q == T_END && last_q) begin
				seen_q       <= SEEN_NONE;
				cand_valid_q <= 1'b0;
			end
			out_valid_q <= load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q    <= '{x: point_x, y: point_y, z: point_z};
			last_q <= stream_last;
		end
		if (state_q == T_DISPATCH && seen_q == SEEN_NONE) begin
			prev_q <= p_q;
		end
		if (state_q == T_DISPATCH && seen_q == SEEN_ONE) begin
			vert_q <= p_q;
		end
		if (state_q == T_CAND_WAIT && ang_res.done) begin
			prev_q <= vert_q;
			vert_q <= ang_res.smooth ? p_q : cand_q;
		end
		if (state_q == T_MAIN_WAIT && ang_res.done) begin
			if (ang_res.smooth) begin
				prev_q <= vert_q;
				vert_q <= p_q;
			end else begin
				cand_q <= p_q;
			end
		end
		for (int i = 0; i < MAX_RES; i++) begin
			if (push0 && cnt_q[QIDX_W-1:0] == QIDX_W'(i)) begin
				q_q[i] <= d0;
			end
			if (push1 && cnt_p1[QIDX_W-1:0] == QIDX_W'(i)) begin
				q_q[i] <= d1;
			end
		end
		if (load) begin
			out_q      <= q_q[rd_q[QIDX_W-1:0]];
			out_last_q <= (rd_q + QCNT_W'(1) == cnt_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_x        = out_q.pt.x;
	assign out_y        = out_q.pt.y;
	assign out_z        = out_q.pt.z;
	assign kind         = out_q.kind;
	assign last_of_item = out_last_q;

	`PCS_ASSERT_IMPL(a_idle_drained, state_q == T_IDLE, rd_q == cnt_q, "ready with results still queued")
	`PCS_ASSERT_IMPL(a_queue_bound, 1'b1, cnt_q <= QCNT_W'(MAX_RES), "result queue overrun")
	`PCS_ASSERT_IMPL(a_done_in_wait, ang_res.done, state_q == T_CAND_WAIT || state_q == T_MAIN_WAIT, "angle result with nobody waiting")

endmodule

@@ sv/pcs_mac.sv @@
module pcs_mac (
	input  logic                         clk,
	input  pcs_pkg::mac_ctl_t            ctl,
	input  logic [pcs_pkg::MUL_A_W-1:0]  op_a,
	input  logic [pcs_pkg::MUL_B_W-1:0]  op_b,
	output logic [pcs_pkg::ACC_W-1:0]    acc
);
	import pcs_pkg::*;

	logic [PROD_W-1:0] prod;
	logic [ACC_W-1:0]  term;
	logic [ACC_W-1:0]  addend;
	logic [ACC_W-1:0]  base;
	logic [ACC_W-1:0]  acc_q;

	always_comb begin
		prod = PROD_W'(op_a) * PROD_W'(op_b);
		unique case (ctl.shift)
			SH_B:    term = ACC_W'(prod) << MUL_B_W;
			SH_A:    term = ACC_W'(prod) << MUL_A_W;
			default: term = ACC_W'(prod);
		endcase
		addend = ctl.neg ? (ACC_W'(0) - term) : term;
		base   = ctl.clear ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + addend;
		end
	end

	assign acc = acc_q;

endmodule

@@ sv/pcs_angle.sv @@
`include "assert_macros.svh"

module pcs_angle (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pcs_pkg::PLANE_W-1:0]  plane,
	input  logic [pcs_pkg::COS2_W-1:0]   cos2,
	input  pcs_pkg::point_t              pa,
	input  pcs_pkg::point_t              pb,
	input  pcs_pkg::point_t              pc,
	output pcs_pkg::ang_res_t            res
);
	import pcs_pkg::*;

	function automatic logic [2*COORD_W-1:0] plane_uw(input point_t p,
			input logic [PLANE_W-1:0] pl);
		logic [2*COORD_W-1:0] r;
		unique case (plane_t'(pl))
			PLANE_XY: r = {p.x, p.y};
			PLANE_YZ: r = {p.y, p.z};
			default:  r = {p.x, p.z};
		endcase
		return r;
	endfunction

	// sign and magnitude of hi - lo
	function automatic logic [MAG_W:0] diff_sm(input logic [COORD_W-1:0] hi,
			input logic [COORD_W-1:0] lo);
		logic [COORD_W:0] d;
		logic [COORD_W:0] m;
		d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
		m = d[COORD_W] ? ((COORD_W+1)'(0) - d) : d;
		return {d[COORD_W], m[MAG_W-1:0]};
	endfunction

	ang_step_t            step_q, step_d;
	logic                 done_q;
	logic                 smooth_q;
	logic [2*COORD_W-1:0] a_uw, b_uw, c_uw;
	logic [MAG_W:0]       x1_sm, y1_sm, x2_sm, y2_sm;
	logic [MAG_W-1:0]     x1m_q, y1m_q, x2m_q, y2m_q;
	logic                 sx_q, sy_q;
	logic [NORM_W-1:0]    dmag_q, n1_q, n2_q;
	logic [SQ_W-1:0]      sq_q;
	logic [SQ_W-MUL_A_W-1:0] nnh_q;
	logic [ACC_W-1:0]     acc;
	logic [ACC_W-1:0]     dot_abs;
	logic [ACC_W-1:0]     lhs;
	mac_ctl_t             ctl;
	logic [MUL_A_W-1:0]   op_a;
	logic [MUL_B_W-1:0]   op_b;

	pcs_mac u_mac (
		.clk  (clk),
		.ctl  (ctl),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	always_comb begin
		a_uw  = plane_uw(pa, plane);
		b_uw  = plane_uw(pb, plane);
		c_uw  = plane_uw(pc, plane);
		x1_sm = diff_sm(b_uw[2*COORD_W-1:COORD_W], a_uw[2*COORD_W-1:COORD_W]);
		y1_sm = diff_sm(b_uw[COORD_W-1:0], a_uw[COORD_W-1:0]);
		x2_sm = diff_sm(c_uw[2*COORD_W-1:COORD_W], b_uw[2*COORD_W-1:COORD_W]);
		y2_sm = diff_sm(c_uw[COORD_W-1:0], b_uw[COORD_W-1:0]);
		dot_abs = acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;
		lhs     = ACC_W'({sq_q, Q_SHIFT'(0)});
	end

	// step sequencer: M1..M2 dot, M3..M6 norms, M7..M8 dot^2,
	// M9..M10 |v1|^2*|v2|^2, M11..M12 times cos2, then compare
	always_comb begin
		if (step_q == A_IDLE) begin
			step_d = start ? A_M1 : A_IDLE;
		end else if (step_q == A_CMP) begin
			step_d = A_IDLE;
		end else begin
			step_d = ang_step_t'(step_q + 4'd1);
		end
	end

	always_comb begin
		ctl  = '{en: 1'b0, clear: 1'b0, neg: 1'b0, shift: SH_NONE};
		op_a = '0;
		op_b = '0;
		unique case (step_q)
			A_M1: begin
				ctl.en = 1'b1; ctl.clear = 1'b1; ctl.neg = sx_q;
				op_a = MUL_A_W'(x1m_q); op_b = MUL_B_W'(x2m_q);
			end
			A_M2: begin
				ctl.en = 1'b1; ctl.neg = sy_q;
				op_a = MUL_A_W'(y1m_q); op_b = MUL_B_W'(y2m_q);
			end
			A_M3: begin
				ctl.en = 1'b1; ctl.clear = 1'b1;
				op_a = MUL_A_W'(x1m_q); op_b = MUL_B_W'(x1m_q);
			end
			A_M4: begin
				ctl.en = 1'b1;
				op_a = MUL_A_W'(y1m_q); op_b = MUL_B_W'(y1m_q);
			end
			A_M5: begin
				ctl.en = 1'b1; ctl.clear = 1'b1;
				op_a = MUL_A_W'(x2m_q); op_b = MUL_B_W'(x2m_q);
			end
			A_M6: begin
				ctl.en = 1'b1;
				op_a = MUL_A_W'(y2m_q); op_b = MUL_B_W'(y2m_q);
			end
			A_M7: begin
				ctl.en = 1'b1; ctl.clear = 1'b1;
				op_a = dmag_q; op_b = dmag_q[MUL_B_W-1:0];
			end
			A_M8: begin
				ctl.en = 1'b1; ctl.shift = SH_B;
				op_a = dmag_q; op_b = MUL_B_W'(dmag_q[NORM_W-1:MUL_B_W]);
			end
			A_M9: begin
				ctl.en = 1'b1; ctl.clear = 1'b1;
				op_a = n1_q; op_b = n2_q[MUL_B_W-1:0];
			end
			A_M10: begin
				ctl.en = 1'b1; ctl.shift = SH_B;
				op_a = n1_q; op_b = MUL_B_W'(n2_q[NORM_W-1:MUL_B_W]);
			end
			A_M11: begin
				ctl.en = 1'b1; ctl.clear = 1'b1;
				op_a = acc[MUL_A_W-1:0]; op_b = cos2;
			end
			A_M12: begin
				ctl.en = 1'b1; ctl.shift = SH_A;
				op_a = MUL_A_W'(nnh_q); op_b = cos2;
			end
			A_IDLE, A_CMP: begin
			end
			default: begin
			end
		endcase
	end

	// partial results are picked off the accumulator as the next pass clears it
	always_ff @(posedge clk) begin
		if (start && step_q == A_IDLE) begin
			x1m_q <= x1_sm[MAG_W-1:0];
			y1m_q <= y1_sm[MAG_W-1:0];
			x2m_q <= x2_sm[MAG_W-1:0];
			y2m_q <= y2_sm[MAG_W-1:0];
			sx_q  <= x1_sm[MAG_W] ^ x2_sm[MAG_W];
			sy_q  <= y1_sm[MAG_W] ^ y2_sm[MAG_W];
		end
		if (step_q == A_M3) begin
			dmag_q <= dot_abs[NORM_W-1:0];
		end
		if (step_q == A_M5) begin
			n1_q <= acc[NORM_W-1:0];
		end
		if (step_q == A_M7) begin
			n2_q <= acc[NORM_W-1:0];
		end
		if (step_q == A_M9) begin
			sq_q <= acc[SQ_W-1:0];
		end
		if (step_q == A_M11) begin
			nnh_q <= acc[SQ_W-1:MUL_A_W];
		end
		if (step_q == A_CMP) begin
			smooth_q <= lhs > acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= A_IDLE;
			done_q <= 1'b0;
		end else begin
			step_q <= step_d;
			done_q <= (step_q == A_CMP);
		end
	end

	assign res = '{done: done_q, smooth: smooth_q};

	`PCS_ASSERT_IMPL(a_start_when_idle, start, step_q == A_IDLE, "angle test started while busy")
	`PCS_ASSERT_NEXT(a_done_after_cmp, step_q == A_CMP, done_q && step_q == A_IDLE, "compare did not finish the test")

endmodule
